>>> rtl/hcbp_pkg.sv
// Huffman code bit packer: shared item types and fixed constants.
// No dependencies; used by the channel interfaces and the top level.
package hcbp_pkg;

  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int ENTRY_W  = CODE_W + LEN_W;
  localparam int SYM_W    = 5;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_A         = 8'd97;
  localparam logic [7:0] CH_Z         = 8'd122;
  localparam logic [SYM_W-1:0] SPACE_SYMBOL = 5'd26;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SYM_W-1:0]  symbol_index;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [7:0]        char_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       bad_symbol;
    logic       last;
    logic       stream_end;
  } out_item_t;

endpackage

>>> rtl/hcbp_if.sv
// Valid/ready channel interfaces for the code bit packer.
// Depends on hcbp_pkg for the item types.
interface hcbp_in_if;
  import hcbp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 27
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/huffman_code_bit_packer_top.sv
// Huffman code bit packer top level: code table RAM and a bit-serial packer.
// Depends on hcbp_pkg, hcbp_in_if / hcbp_out_if and hcbp_ram.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, symbol_index, code_bits, code_length, char_byte
//   out_ch   out  valid/ready   out_byte, has_byte, bad_symbol, last, stream_end
//
// Load item: no result. Newline or bad character: one result.
// Character: a table RAM read, then one code bit per cycle through the shift loop
// while no full byte is held; n-bit codes, n up to min(MAX_CODE_LEN, CODE_W).
// Synchronous active-low reset; the code table is not cleared and holds
// garbage until loaded. A full byte waits in the shift loop while the output
// register is occupied and not taken.
module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 27
) (
  input  logic        clk,
  input  logic        rst_n,
  hcbp_in_if.sink     in_ch,
  hcbp_out_if.source  out_ch
);
  import hcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LW      = $clog2(LEN_CAP + 1);
  localparam int AW      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_SHIFT, S_RESULT} state_t;

  state_t            state_r,     state_nxt;
  logic [CODE_W-1:0] code_r,      code_nxt;
  logic [LW-1:0]     rem_r,       rem_nxt;
  logic [6:0]        acc_r,       acc_nxt;
  logic [2:0]        cnt_r,       cnt_nxt;
  out_item_t         res_r,       res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r,  out_data_nxt;

  logic              in_acc;
  logic              slot_free;
  logic              is_nl;
  logic              is_letter;
  logic              is_space;
  logic [7:0]        letter_off;
  logic [SYM_W-1:0]  sym_idx;
  logic              sym_ok;
  logic              load_ok;
  logic [LEN_W-1:0]  len_sat;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [LEN_W-1:0]  rd_len;
  logic              shift_bit;
  logic [7:0]        flush_byte;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // character to symbol
  assign is_nl      = (in_ch.data.char_byte == CH_NEWLINE);
  assign is_space   = (in_ch.data.char_byte == CH_SPACE);
  assign is_letter  = (in_ch.data.char_byte >= CH_A) && (in_ch.data.char_byte <= CH_Z);
  assign letter_off = in_ch.data.char_byte - CH_A;
  assign sym_idx    = is_space ? SPACE_SYMBOL : letter_off[SYM_W-1:0];
  assign sym_ok     = (is_space || is_letter) && (32'(sym_idx) < NUM_SYMBOLS);

  // table load
  assign load_ok   = (32'(in_ch.data.symbol_index) < NUM_SYMBOLS);
  assign len_sat   = (32'(in_ch.data.code_length) > LEN_CAP) ? LEN_W'(LEN_CAP)
                                                             : in_ch.data.code_length;
  assign ram_we    = in_acc && (in_ch.data.kind == KIND_LOAD) && load_ok;
  assign ram_waddr = AW'(32'(in_ch.data.symbol_index));
  assign ram_wdata = {in_ch.data.code_bits, len_sat};
  assign ram_re    = in_acc && (in_ch.data.kind == KIND_CHAR);
  assign ram_raddr = AW'(32'(sym_idx));
  assign rd_len    = ram_rdata[LEN_W-1:0];

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign shift_bit  = code_r[0];
  assign flush_byte = 8'({1'b0, acc_r} << (4'd8 - {1'b0, cnt_r}));

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.data.kind == KIND_CHAR)) begin
          if (is_nl) begin
            res_nxt.out_byte   = flush_byte;
            res_nxt.has_byte   = (cnt_r != 3'd0);
            res_nxt.bad_symbol = 1'b0;
            res_nxt.last       = 1'b1;
            res_nxt.stream_end = 1'b1;
            acc_nxt            = '0;
            cnt_nxt            = '0;
            state_nxt          = S_RESULT;
          end else if (!sym_ok) begin
            res_nxt.out_byte   = '0;
            res_nxt.has_byte   = 1'b0;
            res_nxt.bad_symbol = 1'b1;
            res_nxt.last       = 1'b1;
            res_nxt.stream_end = 1'b0;
            state_nxt          = S_RESULT;
          end else begin
            state_nxt = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        code_nxt  = ram_rdata[ENTRY_W-1:LEN_W];
        rem_nxt   = LW'(rd_len);
        state_nxt = (rd_len != '0) ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        if (cnt_r != 3'd7 || slot_free) begin
          code_nxt = code_r >> 1;
          rem_nxt  = rem_r - LW'(1);
          if (cnt_r == 3'd7) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.out_byte   = {acc_r, shift_bit};
            out_data_nxt.has_byte   = 1'b1;
            out_data_nxt.bad_symbol = 1'b0;
            out_data_nxt.last       = (32'(rem_r) <= 8);
            out_data_nxt.stream_end = 1'b0;
            acc_nxt                 = '0;
            cnt_nxt                 = '0;
          end else begin
            acc_nxt = {acc_r[5:0], shift_bit};
            cnt_nxt = cnt_r + 3'd1;
          end
          if (rem_r == LW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r     <= code_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.stream_end |-> out_data_r.last)
    else $error("stream end item without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.has_byte |-> out_data_r.out_byte == 8'd0)
    else $error("item without byte carries nonzero data");

  a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.data.kind == KIND_CHAR) && is_nl |=> cnt_r == 3'd0 && acc_r == 7'd0)
    else $error("newline did not clear pending bits");

  a_shift_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> rem_r != '0)
    else $error("shift loop with no bits left");

endmodule
